### hdl/fvts_pkg.sv
// shared constants, types and tables for the four-voice tone synth
package fvts_pkg;

  localparam int PHASE_FRAC_BITS = 24;
  localparam int NUM_VOICES      = 4;
  localparam int VOICE_W         = 2;
  localparam int PERIOD_W        = 11;
  localparam int LEVEL_W         = 4;
  localparam int FRAME_W         = 32;
  localparam int SIF_W           = 10;
  localparam int CFG_W           = 8;
  localparam int CFG_IDX_W       = 2;

  localparam logic [SIF_W-1:0]    SAMPLES_PER_FRAME = SIF_W'(44100 / 60);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX        = PERIOD_W'(2047);

  // cpu clock in phase units per sample, divided by the per-voice timer divisor
  localparam longint unsigned INC_NUM = (64'd1789773 << PHASE_FRAC_BITS) / 64'd44100;
  localparam int INC_W      = $clog2(INC_NUM + 1);
  localparam int ENV_NUM_W  = LEVEL_W + CFG_W + 16;
  localparam int DVD_RAW_W  = (INC_W > ENV_NUM_W) ? INC_W : ENV_NUM_W;
  localparam int DVD_W      = DVD_RAW_W + (DVD_RAW_W % 2);
  localparam int DSR_W      = 17;
  localparam int ACC_W      = PHASE_FRAC_BITS + 4;
  localparam int WHOLE_W    = ACC_W - PHASE_FRAC_BITS;
  localparam int TERM_W     = 18;
  localparam int AMP_W      = 16;

  localparam logic       FUNC_NOTE = 1'b0;
  localparam logic       FUNC_TICK = 1'b1;

  localparam logic [VOICE_W-1:0] VOICE_PULSE0 = 2'd0;
  localparam logic [VOICE_W-1:0] VOICE_PULSE1 = 2'd1;
  localparam logic [VOICE_W-1:0] VOICE_TRI    = 2'd2;
  localparam logic [VOICE_W-1:0] VOICE_NOISE  = 2'd3;

  localparam logic [1:0] SWEEP_DOWN = 2'd1;
  localparam logic [1:0] SWEEP_UP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DECAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRI_GATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_DECAY = 2'd2;

  localparam logic [AMP_W-1:0] TRI_AMP = AMP_W'(15728);

  typedef struct packed {
    logic                       on;
    logic [PERIOD_W-1:0]        period;
    logic [LEVEL_W-1:0]         level;
    logic [1:0]                 duty;
    logic [1:0]                 sweep;
    logic [FRAME_W-1:0]         start_frame;
    logic [PHASE_FRAC_BITS-1:0] phase;
  } voice_ent_t;

  typedef struct packed {
    logic               we;
    logic [VOICE_W-1:0] addr;
    voice_ent_t         data;
  } vram_wr_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NOTE, ST_RD, ST_AGE, ST_LOAD, ST_INC, ST_ENV, ST_TERM, ST_MIX, ST_DONE
  } seq_state_t;

  // twice the noise timer period for each table index
  function automatic logic [12:0] noise_div(input logic [3:0] idx);
    logic [12:0] d;
    unique case (idx)
      4'd0:    d = 13'd8;
      4'd1:    d = 13'd16;
      4'd2:    d = 13'd32;
      4'd3:    d = 13'd64;
      4'd4:    d = 13'd128;
      4'd5:    d = 13'd192;
      4'd6:    d = 13'd256;
      4'd7:    d = 13'd320;
      4'd8:    d = 13'd404;
      4'd9:    d = 13'd508;
      4'd10:   d = 13'd760;
      4'd11:   d = 13'd1016;
      4'd12:   d = 13'd1524;
      4'd13:   d = 13'd2032;
      4'd14:   d = 13'd4068;
      default: d = 13'd8136;
    endcase
    return d;
  endfunction

  function automatic logic [15:0] duty_limit(input logic [1:0] duty);
    logic [15:0] lim;
    unique case (duty)
      2'd0:    lim = 16'd8192;
      2'd1:    lim = 16'd16384;
      2'd2:    lim = 16'd32768;
      default: lim = 16'd49152;
    endcase
    return lim;
  endfunction

endpackage

### hdl/four_voice_tone_synth_top.sv
// four-voice tone synth top level: sequencer, mixer and configuration registers
//
// A note write passes through the note and done states, and the done state loads its
// result into the output register. A sample tick visits the four voices in turn
// through the voice memory and the shared two-bit-per-cycle divider: a phase step
// divide plus an envelope divide for each sounding pulse or noise voice, the phase
// step divide alone for a sounding triangle, none for a silent voice, then the mix.
// One item is in work at a time; the next item is taken while the previous result
// still waits in the output register. Voice state clears at reset through
// per-entry valid bits, with no clearing pass.
module four_voice_tone_synth_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [1:0]         in_voice,
  input  logic [10:0]        in_tone_period,
  input  logic [3:0]         in_loudness,
  input  logic [1:0]         in_duty_select,
  input  logic [1:0]         in_sweep_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pcm_sample,
  output logic               out_note_rejected,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import fvts_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [VOICE_W-1:0]     voice_r;
  logic [PERIOD_W-1:0]    period_r;
  logic [LEVEL_W-1:0]     level_r;
  logic [1:0]             duty_r;
  logic [1:0]             sweep_r;

  logic [CFG_W-1:0]       pdecay_r;
  logic [CFG_W-1:0]       tgate_r;
  logic [CFG_W-1:0]       ndecay_r;

  logic [FRAME_W-1:0]     frame_r;
  logic [SIF_W-1:0]       sif_r;
  logic [14:0]            lfsr_r;
  logic [VOICE_W-1:0]     vidx_r;
  voice_ent_t             ent_r;
  logic [FRAME_W-1:0]     age_r;
  logic [PHASE_FRAC_BITS-1:0] phase_r;
  logic [AMP_W-1:0]       amp_r;
  logic signed [TERM_W-1:0] mix_r;
  logic signed [15:0]     res_pcm_r;
  logic                   res_rej_r;
  logic                   out_valid_r;
  logic signed [15:0]     out_pcm_r;
  logic                   out_rej_r;

  voice_ent_t             rdata;
  vram_wr_t               vwr;
  div_req_t               dreq;
  logic                   div_busy;
  logic [DVD_W-1:0]       div_quot;
  logic                   out_load;
  logic                   note_reject;

  // sweep and timer divisor
  logic [PERIOD_W-1:0]    swp_p;
  logic [PERIOD_W:0]      up_sum;
  logic [PERIOD_W:0]      p1;
  logic [3:0]             nidx;
  logic [DSR_W-1:0]       tone_div;

  // phase step and envelope
  logic [ACC_W-1:0]       acc;
  logic [PHASE_FRAC_BITS-1:0] new_phase;
  logic [WHOLE_W-1:0]     whole;
  logic [14:0]            lfsr_nxt;
  logic [CFG_W-1:0]       env_len;
  logic [CFG_W-1:0]       env_en;
  logic [CFG_W-1:0]       env_ed;
  logic [11:0]            lvl_en;
  logic [DVD_W-1:0]       env_num;
  logic [DSR_W-1:0]       env_den;

  // voice term
  logic [15:0]            ph16;
  logic signed [19:0]     tri_wave;
  logic [AMP_W-1:0]       tri_amp;
  logic signed [35:0]     tri_prod;
  logic signed [35:0]     tri_adj;
  logic signed [TERM_W-1:0] amp_s;
  logic signed [TERM_W-1:0] term;

  // mix output
  logic signed [TERM_W-1:0] mix_c;
  logic signed [33:0]     pcm_prod;
  logic signed [33:0]     pcm_adj;

  fvts_vram u_vram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_i    (vwr),
    .raddr_i (vidx_r),
    .rdata_o (rdata)
  );

  fvts_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (dreq),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  assign note_reject = (voice_r == VOICE_NOISE) && (period_r >= PERIOD_W'(16));

  // sweep, clamp and timer divisor
  always_comb begin
    up_sum = {1'b0, ent_r.period} + {1'b0, age_r[PERIOD_W-1:0]};
    unique case (ent_r.sweep)
      SWEEP_DOWN: swp_p = (age_r >= FRAME_W'(ent_r.period)) ? '0
                          : ent_r.period - age_r[PERIOD_W-1:0];
      SWEEP_UP:   swp_p = ((age_r >= FRAME_W'(PERIOD_MAX)) || (up_sum > {1'b0, PERIOD_MAX}))
                          ? PERIOD_MAX : up_sum[PERIOD_W-1:0];
      default:    swp_p = ent_r.period;
    endcase
    nidx = (swp_p > PERIOD_W'(15)) ? 4'd15 : swp_p[3:0];
    p1   = {1'b0, swp_p} + (PERIOD_W+1)'(1);
    if (vidx_r == VOICE_NOISE) begin
      tone_div = DSR_W'(noise_div(nidx));
    end else if (vidx_r == VOICE_TRI) begin
      tone_div = DSR_W'({p1, 5'b0});
    end else begin
      tone_div = DSR_W'({p1, 4'b0});
    end
  end

  // phase advance, noise clocking and envelope ratio
  always_comb begin
    acc       = ACC_W'(ent_r.phase) + div_quot[ACC_W-1:0];
    new_phase = acc[PHASE_FRAC_BITS-1:0];
    whole     = acc[ACC_W-1:PHASE_FRAC_BITS];
    lfsr_nxt  = lfsr_r;
    for (int k = 0; k < 8; k++) begin
      if (WHOLE_W'(k) < whole) begin
        lfsr_nxt = {lfsr_nxt[0] ^ lfsr_nxt[1], lfsr_nxt[14:1]};
      end
    end
    env_len = (vidx_r == VOICE_NOISE) ? ndecay_r : pdecay_r;
    if (env_len == '0) begin
      env_en = CFG_W'(1);
      env_ed = CFG_W'(1);
    end else if (age_r >= FRAME_W'(env_len)) begin
      env_en = '0;
      env_ed = CFG_W'(1);
    end else begin
      env_en = env_len - age_r[CFG_W-1:0];
      env_ed = env_len;
    end
    lvl_en  = 12'(ent_r.level) * 12'(env_en);
    env_num = DVD_W'({lvl_en, 16'h0000});
    env_den = (vidx_r == VOICE_NOISE) ? DSR_W'(DSR_W'(125) * DSR_W'(env_ed))
                                      : DSR_W'(DSR_W'(75) * DSR_W'(env_ed));
  end

  // one voice's contribution
  always_comb begin
    ph16     = phase_r[PHASE_FRAC_BITS-1 -: 16];
    tri_wave = (ph16 < 16'd32768) ? ($signed({2'b00, ph16, 2'b00}) - 20'sd65536)
                                  : (20'sd196608 - $signed({2'b00, ph16, 2'b00}));
    tri_amp  = ((tgate_r != '0) && (age_r >= FRAME_W'(tgate_r))) ? '0 : TRI_AMP;
    tri_prod = tri_wave * $signed({1'b0, tri_amp});
    tri_adj  = tri_prod + (tri_prod[35] ? 36'sd65535 : 36'sd0);
    amp_s    = $signed(TERM_W'(amp_r));
    unique case (vidx_r)
      VOICE_TRI:   term = tri_adj[TERM_W+15:16];
      VOICE_NOISE: term = lfsr_r[0] ? -amp_s : amp_s;
      default:     term = (ph16 < duty_limit(ent_r.duty)) ? amp_s : -amp_s;
    endcase
    if (!ent_r.on) begin
      term = '0;
    end
  end

  // clamp and scale to pcm
  always_comb begin
    if (mix_r > TERM_W'(65536)) begin
      mix_c = TERM_W'(65536);
    end else if (mix_r < -TERM_W'(65536)) begin
      mix_c = -TERM_W'(65536);
    end else begin
      mix_c = mix_r;
    end
    pcm_prod = mix_c * 34'sd28000;
    pcm_adj  = pcm_prod + (pcm_prod[33] ? 34'sd65535 : 34'sd0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == FUNC_NOTE) ? ST_NOTE : ST_RD;
        end
      end
      ST_NOTE: state_nxt = ST_DONE;
      ST_RD:   state_nxt = ST_AGE;
      ST_AGE:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ent_r.on ? ST_INC : ST_TERM;
      ST_INC: begin
        if (!div_busy) begin
          state_nxt = (vidx_r == VOICE_TRI) ? ST_TERM : ST_ENV;
        end
      end
      ST_ENV: begin
        if (!div_busy) begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: state_nxt = (vidx_r == VOICE_NOISE) ? ST_MIX : ST_RD;
      ST_MIX:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    vwr.we        = 1'b0;
    vwr.addr      = vidx_r;
    vwr.data      = ent_r;
    dreq.start    = 1'b0;
    dreq.dividend = DVD_W'(INC_NUM);
    dreq.divisor  = tone_div;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_NOTE: begin
        vwr.we                = !note_reject;
        vwr.addr              = voice_r;
        vwr.data.on           = (level_r != '0);
        vwr.data.period       = period_r;
        vwr.data.level        = level_r;
        vwr.data.duty         = duty_r;
        vwr.data.sweep        = sweep_r;
        vwr.data.start_frame  = frame_r;
        vwr.data.phase        = '0;
      end
      ST_LOAD: dreq.start = ent_r.on;
      ST_INC: begin
        vwr.we         = !div_busy;
        vwr.data.phase = new_phase;
        dreq.start     = !div_busy && (vidx_r != VOICE_TRI);
        dreq.dividend  = env_num;
        dreq.divisor   = env_den;
      end
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pdecay_r <= CFG_W'(20);
      tgate_r  <= '0;
      ndecay_r <= CFG_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_DECAY: pdecay_r <= cfg_wdata;
        CFG_TRI_GATE:    tgate_r  <= cfg_wdata;
        CFG_NOISE_DECAY: ndecay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      sif_r       <= '0;
      lfsr_r      <= 15'd1;
      vidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: vidx_r <= '0;
        ST_INC: begin
          if (!div_busy && (vidx_r == VOICE_NOISE)) begin
            lfsr_r <= lfsr_nxt;
          end
        end
        ST_TERM: vidx_r <= vidx_r + 1'b1;
        ST_MIX: begin
          if (sif_r == SAMPLES_PER_FRAME - 1'b1) begin
            sif_r   <= '0;
            frame_r <= frame_r + 1'b1;
          end else begin
            sif_r <= sif_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      voice_r  <= in_voice;
      period_r <= in_tone_period;
      level_r  <= in_loudness;
      duty_r   <= in_duty_select;
      sweep_r  <= in_sweep_mode;
      mix_r    <= '0;
    end
    unique case (state_r)
      ST_NOTE: begin
        res_pcm_r <= '0;
        res_rej_r <= note_reject;
      end
      ST_AGE: begin
        ent_r <= rdata;
        age_r <= frame_r - rdata.start_frame;
      end
      ST_INC: begin
        if (!div_busy) begin
          phase_r <= new_phase;
        end
      end
      ST_ENV: begin
        if (!div_busy) begin
          amp_r <= div_quot[AMP_W-1:0];
        end
      end
      ST_TERM: mix_r <= mix_r + term;
      ST_MIX: begin
        res_pcm_r <= pcm_adj[31:16];
        res_rej_r <= 1'b0;
      end
      default: ;
    endcase
    if (out_load) begin
      out_pcm_r <= res_pcm_r;
      out_rej_r <= res_rej_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pcm_sample    = out_pcm_r;
  assign out_note_rejected = out_rej_r;

endmodule

### hdl/fvts_vram.sv
// voice state memory, one entry per voice, registered read, cleared by valid bits
module fvts_vram (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fvts_pkg::vram_wr_t       wr_i,
  input  logic [1:0]               raddr_i,
  output fvts_pkg::voice_ent_t     rdata_o
);
  import fvts_pkg::*;

  voice_ent_t            mem_r [NUM_VOICES];
  logic [NUM_VOICES-1:0] vld_r;
  voice_ent_t            rd_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_i.we) begin
      mem_r[wr_i.addr] <= wr_i.data;
    end
    rd_r <= mem_r[raddr_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_r[wr_i.addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr_i];
    end
  end

  assign rdata_o = rd_vld_r ? rd_r : '0;

endmodule

### hdl/fvts_div.sv
// shared restoring divider, two quotient bits per cycle
module fvts_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fvts_pkg::div_req_t           req_i,
  output logic                         busy_o,
  output logic [fvts_pkg::DVD_W-1:0]   quot_o
);
  import fvts_pkg::*;

  localparam int STEPS = DVD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DSR_W:0]   s1;
  logic [DSR_W:0]   s2;

  // returns {quotient bit, new remainder}
  function automatic logic [DSR_W:0] div_step(input logic [DSR_W-1:0] rem,
                                               input logic b,
                                               input logic [DSR_W-1:0] den);
    logic [DSR_W:0] t;
    logic [DSR_W:0] d;
    t = {rem, b};
    d = {1'b0, den};
    if (t >= d) begin
      return {1'b1, DSR_W'(t - d)};
    end
    return {1'b0, t[DSR_W-1:0]};
  endfunction

  always_comb begin
    s1 = div_step(rem_r, dvd_r[DVD_W-1], den_r);
    s2 = div_step(s1[DSR_W-1:0], dvd_r[DVD_W-2], den_r);
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      dvd_r <= req_i.dividend;
      den_r <= req_i.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-3:0], 2'b00};
      rem_r <= s2[DSR_W-1:0];
      quo_r <= {quo_r[DVD_W-3:0], s1[DSR_W], s2[DSR_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req_i.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy_o = busy_r;
  assign quot_o = quo_r;

endmodule
